// ===== hdl/camera_fragment_reassembler_defines.svh =====
// Assertion macros for the camera fragment reassembler.
// Included by the files that carry concurrent assertions; needs clk and rst in scope.
`ifndef CAMERA_FRAGMENT_REASSEMBLER_DEFINES_SVH
`define CAMERA_FRAGMENT_REASSEMBLER_DEFINES_SVH
`ifndef SYNTHESIS
`define CFR_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("camera fragment reassembler assertion failed");
`define CFR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("camera fragment reassembler assertion failed");
`else
`define CFR_ASSERT_SAME(label, pre, post)
`define CFR_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== hdl/cfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the camera fragment reassembler.
// No dependencies; used by the result queue, the top level and the testbench.
package cfr_pkg;

  localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
  localparam logic [2:0] KIND_FRAME_DONE = 3'd1;
  localparam logic [2:0] KIND_BAD_CAMERA = 3'd2;
  localparam logic [2:0] KIND_OUT_ORDER  = 3'd3;
  localparam logic [2:0] KIND_BAD_SYNC   = 3'd4;

  localparam logic [7:0] SYNC_FIRST  = 8'h47;
  localparam logic [7:0] SYNC_SECOND = 8'h74;

  // Header byte positions, counted from the camera id byte.
  localparam int HDR_TYPE   = 1;
  localparam int HDR_WIDTH  = 2;
  localparam int HDR_HEIGHT = 6;
  localparam int HDR_TIME   = 10;
  localparam int HDR_LENGTH = 14;
  localparam int HDR_TOTAL  = 18;
  localparam int HDR_START  = 22;
  localparam int HDR_END    = 26;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PW    = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  camera;
    logic [31:0] frame_offset;
    logic [7:0]  pixel_byte;
    logic [7:0]  frame_type;
    logic [31:0] frame_width;
    logic [31:0] frame_height;
    logic [31:0] frame_time;
    logic [31:0] frame_length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== hdl/cfr_if.sv =====
`timescale 1ns / 1ps
// Handshake channels of the camera fragment reassembler: the byte stream in
// and the result stream out. No dependencies.
interface cfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface cfr_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  camera;
  logic [31:0] frame_offset;
  logic [7:0]  pixel_byte;
  logic [7:0]  frame_type;
  logic [31:0] frame_width;
  logic [31:0] frame_height;
  logic [31:0] frame_time;
  logic [31:0] frame_length;
  logic        last;

  modport source(output valid, output kind, output camera, output frame_offset,
                 output pixel_byte, output frame_type, output frame_width,
                 output frame_height, output frame_time, output frame_length,
                 output last, input ready);
  modport sink(input valid, input kind, input camera, input frame_offset,
               input pixel_byte, input frame_type, input frame_width,
               input frame_height, input frame_time, input frame_length,
               input last, output ready);
endinterface

// ===== hdl/cfr_result_fifo.sv =====
`timescale 1ns / 1ps
// Four-entry result queue that takes up to two results a cycle and hands them
// out one request at a time. Depends on cfr_pkg and cfr_result_if.
module cfr_result_fifo (
  input  logic           clk,
  input  logic           rst,
  input  cfr_pkg::push_t push,
  output logic           room,
  cfr_result_if.source   results
);
  import cfr_pkg::*;

  result_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]     wptr;
  logic [QUEUE_PW-1:0]     rptr;
  logic [QUEUE_PW:0]       count;
  logic [QUEUE_PW:0]       count_next;
  logic                    pop;
  result_t                 head;

  assign pop  = results.valid && results.ready;
  assign room = count <= (QUEUE_PW + 1)'(QUEUE_DEPTH - 2);
  assign count_next = count + (QUEUE_PW + 1)'(push.count) - (QUEUE_PW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wptr + QUEUE_PW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QUEUE_PW'(push.count);
      rptr  <= rptr + QUEUE_PW'(pop);
      count <= count_next;
    end
  end

  assign head = entries[rptr];

  assign results.valid        = count != '0;
  assign results.kind         = head.kind;
  assign results.camera       = head.camera;
  assign results.frame_offset = head.frame_offset;
  assign results.pixel_byte   = head.pixel_byte;
  assign results.frame_type   = head.frame_type;
  assign results.frame_width  = head.frame_width;
  assign results.frame_height = head.frame_height;
  assign results.frame_time   = head.frame_time;
  assign results.frame_length = head.frame_length;
  assign results.last         = head.last;

endmodule

// ===== hdl/camera_fragment_reassembler.sv =====
`timescale 1ns / 1ps
// Camera fragment reassembler: top level. Depends on cfr_pkg, cfr_if,
// cfr_result_fifo and camera_fragment_reassembler_defines.svh.
// The stream channel takes one raw camera link byte per request. Each fragment
// starts with the sync pair 0x47 0x74 and a header of HEADER_BYTES bytes.
// The results channel returns payload bytes with camera and frame offset,
// frame-done records, and reports of bad sync, bad camera and out-of-order
// fragments; last marks the final result caused by one input byte.
// A byte is taken in every cycle while the result queue has room for two
// results. Its results are registered in the result queue before the results
// channel shows them. A payload byte that completes a frame gives two results.
// The per-camera position and frame information live in small memories with
// a registered read port, fetched while the header streams.
// Reset clears the sync hunt and marks every camera entry as zero; no clearing
// pass is needed. When the receiver stalls, the four-entry queue fills and the
// stream channel drops ready until space for two results is free again.
`include "camera_fragment_reassembler_defines.svh"
module camera_fragment_reassembler #(
  parameter int CAMERA_UNITS = 8,
  parameter int HEADER_BYTES = 26
) (
  input  logic         clk,
  input  logic         rst,
  cfr_byte_if.sink     stream,
  cfr_result_if.source results
);
  import cfr_pkg::*;

  localparam int HBW = $clog2(HEADER_BYTES + 3);
  localparam int CIW = (CAMERA_UNITS > 1) ? $clog2(CAMERA_UNITS) : 1;

  localparam logic [HBW-1:0] HUNT      = HBW'(0);
  localparam logic [HBW-1:0] SYNC2     = HBW'(1);
  localparam logic [HBW-1:0] FIRST_HDR = HBW'(2);
  localparam logic [HBW-1:0] LAST_HDR  = HBW'(HEADER_BYTES + 1);
  localparam logic [HBW-1:0] PAYLOAD   = HBW'(HEADER_BYTES + 2);

  logic [HBW-1:0] hbs;
  logic [HBW-1:0] hbs_next;
  logic [7:0]     sync_held;
  logic [7:0]     sync_held_next;
  logic [7:0]     frag_camera;
  logic [7:0]     frag_camera_next;
  logic [7:0]     frag_type;
  logic [7:0]     frag_type_next;
  logic [31:0]    frag_width;
  logic [31:0]    frag_width_next;
  logic [31:0]    frag_height;
  logic [31:0]    frag_height_next;
  logic [31:0]    frag_time;
  logic [31:0]    frag_time_next;
  logic [31:0]    frag_length;
  logic [31:0]    frag_length_next;
  logic [31:0]    frag_total;
  logic [31:0]    frag_total_next;
  logic [31:0]    frag_start;
  logic [31:0]    frag_start_next;
  logic [31:0]    payload_left;
  logic [31:0]    payload_left_next;
  logic           frag_ok;
  logic           frag_ok_next;
  logic [31:0]    cur_pos;
  logic [31:0]    cur_pos_next;
  logic [7:0]     cur_type;
  logic [7:0]     cur_type_next;
  logic [31:0]    cur_width;
  logic [31:0]    cur_width_next;
  logic [31:0]    cur_height;
  logic [31:0]    cur_height_next;

  logic [31:0]       pos_mem    [CAMERA_UNITS];
  logic [7:0]        type_mem   [CAMERA_UNITS];
  logic [31:0]       width_mem  [CAMERA_UNITS];
  logic [31:0]       height_mem [CAMERA_UNITS];
  logic [CAMERA_UNITS-1:0] pos_valid;
  logic [CAMERA_UNITS-1:0] info_valid;
  logic [31:0]       rd_pos;
  logic [7:0]        rd_type;
  logic [31:0]       rd_width;
  logic [31:0]       rd_height;
  logic              rd_pos_valid;
  logic              rd_info_valid;

  logic [CIW-1:0] addr;
  logic           in_range;
  logic           fire;
  logic           room;
  logic           sync_ok;
  logic [7:0]     b;
  logic [HBW-1:0] k;
  logic [31:0]    pos_e;
  logic [7:0]     info_type;
  logic [31:0]    info_width;
  logic [31:0]    info_height;
  logic [31:0]    new_pos;
  logic           pos_we;
  logic [31:0]    pos_wdata;
  logic           info_we;
  push_t          push;
  result_t        res_a;
  result_t        res_b;

  assign b        = stream.data_byte;
  assign fire     = stream.valid && stream.ready;
  assign stream.ready = room;
  assign addr     = frag_camera[CIW-1:0];
  assign in_range = {1'b0, frag_camera} < 9'(CAMERA_UNITS);
  assign sync_ok  = (sync_held == SYNC_FIRST) && (b == SYNC_SECOND);
  assign k        = hbs - FIRST_HDR;
  assign new_pos  = cur_pos + 32'd1;
  assign pos_e    = rd_pos_valid ? rd_pos : 32'd0;

  always_comb begin
    hbs_next          = hbs;
    sync_held_next    = sync_held;
    frag_camera_next  = frag_camera;
    frag_type_next    = frag_type;
    frag_width_next   = frag_width;
    frag_height_next  = frag_height;
    frag_time_next    = frag_time;
    frag_length_next  = frag_length;
    frag_total_next   = frag_total;
    frag_start_next   = frag_start;
    payload_left_next = payload_left;
    frag_ok_next      = frag_ok;
    cur_pos_next      = cur_pos;
    cur_type_next     = cur_type;
    cur_width_next    = cur_width;
    cur_height_next   = cur_height;
    info_type         = rd_info_valid ? rd_type : 8'd0;
    info_width        = rd_info_valid ? rd_width : 32'd0;
    info_height       = rd_info_valid ? rd_height : 32'd0;
    pos_we            = 1'b0;
    pos_wdata         = 32'd0;
    info_we           = 1'b0;
    res_a             = '0;
    res_b             = '0;
    push.count        = 2'd0;

    if (fire) begin
      if (hbs == HUNT) begin
        sync_held_next = b;
        hbs_next       = SYNC2;
      end else if (hbs == SYNC2) begin
        if (sync_ok) begin
          hbs_next = FIRST_HDR;
        end else begin
          hbs_next   = HUNT;
          res_a.kind = KIND_BAD_SYNC;
          res_a.last = 1'b1;
          push.count = 2'd1;
        end
      end else if (hbs != PAYLOAD) begin
        hbs_next = hbs + HBW'(1);
        if (k == HBW'(0)) begin
          frag_camera_next = b;
        end else if (k == HBW'(HDR_TYPE)) begin
          frag_type_next = b;
        end else if (k < HBW'(HDR_HEIGHT)) begin
          frag_width_next = {frag_width[23:0], b};
        end else if (k < HBW'(HDR_TIME)) begin
          frag_height_next = {frag_height[23:0], b};
        end else if (k < HBW'(HDR_LENGTH)) begin
          frag_time_next = {frag_time[23:0], b};
        end else if (k < HBW'(HDR_TOTAL)) begin
          frag_length_next = {frag_length[23:0], b};
        end else if (k < HBW'(HDR_START)) begin
          frag_total_next = {frag_total[23:0], b};
        end else if (k < HBW'(HDR_END)) begin
          frag_start_next = {frag_start[23:0], b};
        end

        if (hbs == LAST_HDR) begin
          payload_left_next = frag_length;
          frag_ok_next      = 1'b0;
          hbs_next          = (frag_length == 32'd0) ? HUNT : PAYLOAD;
          if (!in_range) begin
            res_a.kind         = KIND_BAD_CAMERA;
            res_a.camera       = frag_camera;
            res_a.frame_offset = frag_start_next;
            res_a.last         = 1'b1;
            push.count         = 2'd1;
          end else if (frag_start_next != pos_e) begin
            pos_we             = 1'b1;
            pos_wdata          = 32'd0;
            res_a.kind         = KIND_OUT_ORDER;
            res_a.camera       = frag_camera;
            res_a.frame_offset = frag_start_next;
            res_a.last         = 1'b1;
            push.count         = 2'd1;
          end else begin
            frag_ok_next = 1'b1;
            cur_pos_next = pos_e;
            if (frag_start_next == 32'd0) begin
              info_we     = 1'b1;
              info_type   = frag_type;
              info_width  = frag_width;
              info_height = frag_height;
            end
            cur_type_next   = info_type;
            cur_width_next  = info_width;
            cur_height_next = info_height;
            if ((frag_length == 32'd0) && (pos_e == frag_total)) begin
              pos_we             = 1'b1;
              pos_wdata          = 32'd0;
              cur_pos_next       = 32'd0;
              res_a.kind         = KIND_FRAME_DONE;
              res_a.camera       = frag_camera;
              res_a.frame_type   = info_type;
              res_a.frame_width  = info_width;
              res_a.frame_height = info_height;
              res_a.frame_time   = frag_time;
              res_a.frame_length = frag_total;
              res_a.last         = 1'b1;
              push.count         = 2'd1;
            end
          end
        end
      end else begin
        payload_left_next = payload_left - 32'd1;
        if (frag_ok) begin
          res_a.kind         = KIND_PAYLOAD;
          res_a.camera       = frag_camera;
          res_a.frame_offset = cur_pos;
          res_a.pixel_byte   = b;
          res_a.last         = 1'b1;
          push.count         = 2'd1;
          cur_pos_next       = new_pos;
          pos_we             = 1'b1;
          pos_wdata          = new_pos;
        end
        if (payload_left == 32'd1) begin
          hbs_next = HUNT;
          if (frag_ok && (new_pos == frag_total)) begin
            cur_pos_next       = 32'd0;
            pos_wdata          = 32'd0;
            res_a.last         = 1'b0;
            res_b.kind         = KIND_FRAME_DONE;
            res_b.camera       = frag_camera;
            res_b.frame_type   = cur_type;
            res_b.frame_width  = cur_width;
            res_b.frame_height = cur_height;
            res_b.frame_time   = frag_time;
            res_b.frame_length = frag_total;
            res_b.last         = 1'b1;
            push.count         = 2'd2;
          end
        end
      end
    end

    push.first  = res_a;
    push.second = res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hbs     <= HUNT;
      frag_ok <= 1'b0;
    end else begin
      hbs     <= hbs_next;
      frag_ok <= frag_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    sync_held    <= sync_held_next;
    frag_camera  <= frag_camera_next;
    frag_type    <= frag_type_next;
    frag_width   <= frag_width_next;
    frag_height  <= frag_height_next;
    frag_time    <= frag_time_next;
    frag_length  <= frag_length_next;
    frag_total   <= frag_total_next;
    frag_start   <= frag_start_next;
    payload_left <= payload_left_next;
    cur_pos      <= cur_pos_next;
    cur_type     <= cur_type_next;
    cur_width    <= cur_width_next;
    cur_height   <= cur_height_next;
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[addr] <= pos_wdata;
    end
    if (info_we) begin
      type_mem[addr]   <= frag_type;
      width_mem[addr]  <= frag_width;
      height_mem[addr] <= frag_height;
    end
    rd_pos    <= pos_mem[addr];
    rd_type   <= type_mem[addr];
    rd_width  <= width_mem[addr];
    rd_height <= height_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_valid     <= '0;
      info_valid    <= '0;
      rd_pos_valid  <= 1'b0;
      rd_info_valid <= 1'b0;
    end else begin
      if (pos_we) begin
        pos_valid[addr] <= 1'b1;
      end
      if (info_we) begin
        info_valid[addr] <= 1'b1;
      end
      rd_pos_valid  <= pos_valid[addr];
      rd_info_valid <= info_valid[addr];
    end
  end

  cfr_result_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .results (results)
  );

  `CFR_ASSERT_SAME(a_payload_has_bytes, hbs == PAYLOAD, payload_left != 32'd0)
  `CFR_ASSERT_SAME(a_accepted_in_range, (hbs == PAYLOAD) && frag_ok, in_range)
  `CFR_ASSERT_SAME(a_pair_only_in_payload, push.count == 2'd2, fire && (hbs == PAYLOAD))
  `CFR_ASSERT_NEXT(a_bad_sync_rehunts, fire && (hbs == SYNC2) && !sync_ok, hbs == HUNT)

endmodule

// ===== tb/tb_camera_fragment_reassembler.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the camera fragment reassembler: drives framed camera
// link byte streams with random idling and back-pressure, and predicts every result.
// Depends on cfr_pkg, cfr_if and the camera_fragment_reassembler RTL.
module tb_camera_fragment_reassembler;
  import cfr_pkg::*;

  localparam int CAMERA_UNITS = 8;
  localparam int HEADER_BYTES = 26;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_BYTES = 1750;
  localparam int DRAIN_CYCLES = 20;

  class reassembly_scoreboard;
    logic [6:0]  hdr_seen;
    logic [7:0]  held_sync;
    logic [7:0]  frag_camera;
    logic [7:0]  frag_type;
    logic [31:0] frag_width;
    logic [31:0] frag_height;
    logic [31:0] frag_stamp;
    logic [31:0] frag_length;
    logic [31:0] frag_total;
    logic [31:0] frag_start;
    logic [31:0] bytes_left;
    bit          frag_ok;
    logic [31:0] cam_pos [CAMERA_UNITS];
    logic [31:0] cam_width [CAMERA_UNITS];
    logic [31:0] cam_height [CAMERA_UNITS];
    logic [7:0]  cam_type [CAMERA_UNITS];
    result_t     pending_results[$];
    int          errors;

    function new();
      hdr_seen = '0;
      held_sync = '0;
      frag_camera = '0;
      frag_type = '0;
      frag_width = '0;
      frag_height = '0;
      frag_stamp = '0;
      frag_length = '0;
      frag_total = '0;
      frag_start = '0;
      bytes_left = '0;
      frag_ok = 1'b0;
      for (int i = 0; i < CAMERA_UNITS; i++) begin
        cam_pos[i] = '0;
        cam_width[i] = '0;
        cam_height[i] = '0;
        cam_type[i] = '0;
      end
      errors = 0;
    endfunction

    function void add_result(logic [2:0] kind, logic [7:0] cam, logic [31:0] offset,
                             logic [7:0] pixel, logic [7:0] ftype, logic [31:0] width,
                             logic [31:0] height, logic [31:0] stamp, logic [31:0] total);
      result_t r;
      r = '0;
      r.kind = kind;
      r.camera = cam;
      r.frame_offset = offset;
      r.pixel_byte = pixel;
      r.frame_type = ftype;
      r.frame_width = width;
      r.frame_height = height;
      r.frame_time = stamp;
      r.frame_length = total;
      pending_results.push_back(r);
    endfunction

    function void frame_done();
      if (frag_camera < CAMERA_UNITS) begin
        add_result(KIND_FRAME_DONE, frag_camera, '0, '0, cam_type[frag_camera],
                   cam_width[frag_camera], cam_height[frag_camera], frag_stamp,
                   frag_total);
        cam_pos[frag_camera] = '0;
      end
    endfunction

    function void header_complete();
      logic [7:0] c;
      c = frag_camera;
      bytes_left = frag_length;
      frag_ok = 1'b0;
      if (c >= CAMERA_UNITS) begin
        add_result(KIND_BAD_CAMERA, c, frag_start, '0, '0, '0, '0, '0, '0);
      end else if (frag_start != cam_pos[c]) begin
        cam_pos[c] = '0;
        add_result(KIND_OUT_ORDER, c, frag_start, '0, '0, '0, '0, '0, '0);
      end else begin
        frag_ok = 1'b1;
        if (frag_start == 0) begin
          cam_type[c] = frag_type;
          cam_width[c] = frag_width;
          cam_height[c] = frag_height;
        end
        if (frag_length == 0 && cam_pos[c] == frag_total) begin
          frame_done();
        end
      end
      if (frag_length == 0) begin
        hdr_seen = '0;
      end
    endfunction

    function void take_byte(logic [7:0] value);
      int unsigned queued_prior;
      int k;
      logic [7:0] c;
      bit shown;
      queued_prior = pending_results.size();
      if (hdr_seen == 0) begin
        held_sync = value;
        hdr_seen = 7'd1;
      end else if (hdr_seen == 1) begin
        if (held_sync == SYNC_FIRST && value == SYNC_SECOND) begin
          hdr_seen = 7'd2;
        end else begin
          hdr_seen = '0;
          add_result(KIND_BAD_SYNC, '0, '0, '0, '0, '0, '0, '0, '0);
        end
      end else if (hdr_seen < HEADER_BYTES + 2) begin
        k = int'(hdr_seen) - 2;
        if (k == 0) begin
          frag_camera = value;
        end else if (k == HDR_TYPE) begin
          frag_type = value;
        end else if (k < HDR_HEIGHT) begin
          frag_width = {frag_width[23:0], value};
        end else if (k < HDR_TIME) begin
          frag_height = {frag_height[23:0], value};
        end else if (k < HDR_LENGTH) begin
          frag_stamp = {frag_stamp[23:0], value};
        end else if (k < HDR_TOTAL) begin
          frag_length = {frag_length[23:0], value};
        end else if (k < HDR_START) begin
          frag_total = {frag_total[23:0], value};
        end else if (k < HDR_END) begin
          frag_start = {frag_start[23:0], value};
        end
        hdr_seen = hdr_seen + 7'd1;
        if (hdr_seen == HEADER_BYTES + 2) begin
          header_complete();
        end
      end else begin
        c = frag_camera;
        shown = frag_ok && (c < CAMERA_UNITS);
        if (shown) begin
          add_result(KIND_PAYLOAD, c, cam_pos[c], value, '0, '0, '0, '0, '0);
          cam_pos[c] = cam_pos[c] + 32'd1;
        end
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 0) begin
          hdr_seen = '0;
          if (shown && cam_pos[c] == frag_total) begin
            frame_done();
          end
        end
      end
      if (pending_results.size() > queued_prior) begin
        pending_results[pending_results.size() - 1].last = 1'b1;
      end
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit good;
      if (pending_results.size() == 0) begin
        $error("result of kind %0d for camera %0d with no request waiting", got.kind,
               got.camera);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      good = 1'b1;
      good &= field_ok("kind", 32'(want.kind), 32'(got.kind));
      good &= field_ok("camera", 32'(want.camera), 32'(got.camera));
      good &= field_ok("frame_offset", want.frame_offset, got.frame_offset);
      good &= field_ok("pixel_byte", 32'(want.pixel_byte), 32'(got.pixel_byte));
      good &= field_ok("frame_type", 32'(want.frame_type), 32'(got.frame_type));
      good &= field_ok("frame_width", want.frame_width, got.frame_width);
      good &= field_ok("frame_height", want.frame_height, got.frame_height);
      good &= field_ok("frame_time", want.frame_time, got.frame_time);
      good &= field_ok("frame_length", want.frame_length, got.frame_length);
      good &= field_ok("last", 32'(want.last), 32'(got.last));
      if (!good) begin
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  cfr_byte_if   byte_ch();
  cfr_result_if result_ch();

  camera_fragment_reassembler #(
    .CAMERA_UNITS(CAMERA_UNITS),
    .HEADER_BYTES(HEADER_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .stream(byte_ch),
    .results(result_ch)
  );

  reassembly_scoreboard reassembly;
  result_t     seen_result;
  int          bytes_sent;
  int          results_seen;
  int          idle_cycles;
  bit          sender_burst;
  bit          hold_done;
  int          hold_left;
  int          sink_gap;
  int          sink_free;
  logic [31:0] stim_pos [CAMERA_UNITS];
  logic [31:0] stim_total [CAMERA_UNITS];

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    result_ch.ready = 1'b0;
    reassembly = new();
    bytes_sent = 0;
    results_seen = 0;
    sender_burst = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    sink_gap = 0;
    sink_free = 0;
    for (int i = 0; i < CAMERA_UNITS; i++) begin
      stim_pos[i] = '0;
      stim_total[i] = '0;
    end
  end

  always #1 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      return 32'h0;
    end else if (r == 1) begin
      return 32'hFFFF_FFFF;
    end
    return $urandom;
  endfunction

  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = sender_burst ? 0 : gap_len();
    repeat (gap) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid = 1'b1;
    byte_ch.data_byte = value;
    @(posedge clk);
    while (!byte_ch.ready) begin
      @(posedge clk);
    end
    reassembly.take_byte(value);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_word(input logic [31:0] word);
    for (int i = 3; i >= 0; i--) begin
      send_byte(word[8 * i +: 8]);
    end
  endtask

  task automatic send_fragment(input logic [7:0] cam, input logic [31:0] start,
                               input logic [31:0] length, input logic [31:0] total);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(cam);
    send_byte(8'(pick_word()));
    send_word(pick_word());
    send_word(pick_word());
    send_word(pick_word());
    send_word(length);
    send_word(total);
    send_word(start);
    for (int k = HDR_END; k < HEADER_BYTES; k++) begin
      send_byte(8'($urandom));
    end
    for (int unsigned k = 0; k < length; k++) begin
      send_byte(8'($urandom));
    end
  endtask

  task automatic random_fragment();
    int choice;
    logic [7:0] cam;
    logic [7:0] first;
    logic [7:0] second;
    logic [31:0] room;
    logic [31:0] length;
    choice = $urandom_range(0, 99);
    if (choice < 8) begin
      first = ($urandom_range(0, 2) == 0) ? SYNC_FIRST : 8'($urandom);
      second = 8'($urandom);
      if (first == SYNC_FIRST && second == SYNC_SECOND) begin
        second = ~second;
      end
      send_byte(first);
      send_byte(second);
    end else if (choice < 14) begin
      cam = 8'($urandom_range(CAMERA_UNITS, 255));
      send_fragment(cam, pick_word(), $urandom_range(0, 6), pick_word());
    end else if (choice < 20) begin
      cam = 8'($urandom_range(0, CAMERA_UNITS - 1));
      send_fragment(cam, stim_pos[cam] + $urandom_range(1, 40), $urandom_range(0, 6),
                    stim_total[cam]);
      stim_pos[cam] = '0;
    end else begin
      cam = 8'($urandom_range(0, CAMERA_UNITS - 1));
      if (stim_pos[cam] == 0) begin
        if ($urandom_range(0, 19) == 0) begin
          stim_total[cam] = '0;
        end else if ($urandom_range(0, 39) == 0) begin
          stim_total[cam] = $urandom_range(60, 120);
        end else begin
          stim_total[cam] = $urandom_range(1, 48);
        end
      end
      room = (stim_total[cam] > stim_pos[cam]) ? stim_total[cam] - stim_pos[cam] : '0;
      if ($urandom_range(0, 24) == 0) begin
        length = room + $urandom_range(1, 4);
      end else begin
        length = $urandom_range(0, (room > 12) ? 12 : room);
      end
      send_fragment(cam, stim_pos[cam], length, stim_total[cam]);
      stim_pos[cam] = stim_pos[cam] + length;
      if (stim_pos[cam] == stim_total[cam]) begin
        stim_pos[cam] = '0;
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      sender_burst = !sender_burst;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready = 1'b0;
    end else if (hold_left > 0) begin
      result_ch.ready = 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= 100) begin
      hold_done = 1'b1;
      hold_left = $urandom_range(150, 250);
      result_ch.ready = 1'b0;
    end else if (sink_free > 0) begin
      result_ch.ready = 1'b1;
      sink_free--;
    end else if (sink_gap > 0) begin
      result_ch.ready = 1'b0;
      sink_gap--;
    end else begin
      result_ch.ready = 1'b1;
      if ($urandom_range(0, 19) == 0) begin
        sink_free = $urandom_range(20, 80);
      end else begin
        sink_gap = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen_result.kind = result_ch.kind;
      seen_result.camera = result_ch.camera;
      seen_result.frame_offset = result_ch.frame_offset;
      seen_result.pixel_byte = result_ch.pixel_byte;
      seen_result.frame_type = result_ch.frame_type;
      seen_result.frame_width = result_ch.frame_width;
      seen_result.frame_height = result_ch.frame_height;
      seen_result.frame_time = result_ch.frame_time;
      seen_result.frame_length = result_ch.frame_length;
      seen_result.last = result_ch.last;
      reassembly.check_result(seen_result);
      results_seen++;
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Broken sync pairs, including a valid first byte with a wrong second one.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    // A zero-length, zero-total fragment completes its frame as the header ends.
    send_fragment(8'd0, 32'd0, 32'd0, 32'd0);
    // A short frame from the highest camera, completed by its last payload byte.
    send_fragment(8'(CAMERA_UNITS - 1), 32'd0, 32'd3, 32'd3);
    // Cameras out of range, with and without payload.
    send_fragment(8'(CAMERA_UNITS), 32'd0, 32'd2, 32'd2);
    send_fragment(8'hFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    // An offset that does not match the expected position.
    send_fragment(8'd1, 32'd5, 32'd1, 32'd8);
    // A frame in two fragments; only the first one refreshes the frame info.
    send_fragment(8'd2, 32'd0, 32'd2, 32'd4);
    send_fragment(8'd2, 32'd2, 32'd2, 32'd4);
    // A fragment that runs past the total, then a reset by a mismatch.
    send_fragment(8'd3, 32'd0, 32'd3, 32'd2);
    send_fragment(8'd3, 32'd0, 32'd0, 32'd2);

    while (bytes_sent < RANDOM_BYTES) begin
      random_fragment();
    end
    byte_ch.valid = 1'b0;

    while (reassembly.pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (reassembly.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
